// File: src/mfq_pkg.sv
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared types, codes and constants for the mesh fit and grid quantizer.
// ----------------------------------------------------------------------------
package mfq_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int MAX_FACES_DEF    = 31;
    localparam int COORD_BITS_DEF   = 32;

    localparam int GRID_W  = 12;   // digit / face index width
    localparam int LG_W    = 4;
    localparam int VSLOT_W = 6;
    localparam int FSLOT_W = 5;
    localparam int CNT_W   = 16;
    localparam int SEEN_W  = 17;
    localparam int CFG_W   = 6;

    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_VERTEX = 2'd0,
        OP_FACE   = 2'd1,
        OP_FINISH = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_VTX  = 2'd0,
        KIND_FACE = 2'd1,
        KIND_SUM  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_GRID_LOG2    = 2'd0,
        CFG_VERTEX_SLOTS = 2'd1,
        CFG_FACE_SLOTS   = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIDTH,
        S_ADDR,
        S_LOAD,
        S_DIV,
        S_FILL,
        S_SUM
    } t_state;

    // control from the sequencer to every axis lane
    typedef struct packed {
        logic upd;    // vertex request: widen box
        logic clear;  // end of finish run
        logic start;  // begin quantizing one coordinate
        logic fill;   // slot holds a vertex and extent is nonzero
    } t_lane_ctl;

endpackage

// File: src/mfq_ram.sv
// ----------------------------------------------------------------------------
// mfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/mfq_lane.sv
// ----------------------------------------------------------------------------
// mfq_lane
// One axis: bounding box tracking and a bit-serial grid quantizer.
// ----------------------------------------------------------------------------
module mfq_lane #(
    parameter int CW = mfq_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mfq_pkg::t_lane_ctl            i_ctl,
    input  logic signed [CW-1:0]          i_coord,
    input  logic signed [CW-1:0]          i_p,
    input  logic [CW-1:0]                 i_w,
    input  logic [mfq_pkg::LG_W-1:0]      i_lg,
    output logic [CW-1:0]                 o_ext,
    output logic                          o_busy,
    output logic [mfq_pkg::GRID_W-1:0]    o_digit
);
    import mfq_pkg::*;

    localparam int NW = CW + 3;
    localparam logic signed [CW-1:0] TOP = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] BOT = {1'b1, {(CW-1){1'b0}}};

    logic signed [CW-1:0] r_lo, r_hi;
    logic signed [CW:0]   r_sum;
    logic                 r_busy;
    logic [LG_W-1:0]      r_cnt;
    logic [CW:0]          r_rem, r_w2;
    logic [GRID_W-1:0]    r_q;

    logic signed [NW-1:0] w_num;
    logic [CW:0]          w_w2;
    logic [CW+1:0]        w_rem2;
    logic                 w_ge;
    logic [GRID_W:0]      w_cells;
    logic [GRID_W-1:0]    w_half, w_cmax;

    assign w_w2    = {i_w, 1'b0};
    assign w_num   = (NW'(i_p) <<< 1) - NW'(r_sum) + $signed({3'b000, i_w});
    assign w_rem2  = {r_rem, 1'b0};
    assign w_ge    = w_rem2 >= {1'b0, r_w2};
    assign w_cells = (GRID_W+1)'(1) << i_lg;
    assign w_half  = w_cells[GRID_W:1];
    assign w_cmax  = GRID_W'(w_cells - (GRID_W+1)'(1));

    // box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_lo <= TOP;
            r_hi <= BOT;
        end else if (i_ctl.upd) begin
            if (i_coord < r_lo) begin
                r_lo <= i_coord;
            end
            if (i_coord > r_hi) begin
                r_hi <= i_coord;
            end
        end
        r_sum <= (CW+1)'(r_lo) + (CW+1)'(r_hi);
    end

    // quantizer: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_w2 <= w_w2;
            r_cnt <= i_lg;
            r_busy <= 1'b0;
            if (!i_ctl.fill) begin
                r_q <= w_half;
            end else if (w_num < 0) begin
                r_q <= '0;
            end else if (w_num >= $signed({2'b00, w_w2})) begin
                r_q <= w_cmax;
            end else begin
                r_rem  <= w_num[CW:0];
                r_q    <= '0;
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_q   <= {r_q[GRID_W-2:0], w_ge};
            r_rem <= w_ge ? (CW+1)'(w_rem2 - {1'b0, r_w2}) : w_rem2[CW:0];
            r_cnt <= r_cnt - LG_W'(1);
            if (r_cnt == LG_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_ext   = CW'(r_hi - r_lo);
    assign o_busy  = r_busy;
    assign o_digit = r_q;
endmodule

// File: src/mesh_fit_quantize.sv
// ----------------------------------------------------------------------------
// mesh_fit_quantize
// Bounding box fit of a triangle mesh and quantization onto a cubic grid.
// ----------------------------------------------------------------------------
// Vertex and face requests leave busy low; a face result appears on the
// result ports in the cycle after its request. A finish request raises busy
// and plays out the fitted model: it latches the largest extent, then for
// every vertex slot reads memory, takes one quotient bit per cycle in the
// three axis lanes and emits the digits; a slot that is empty or degenerate
// skips the bit loop. Then it emits each filler face and the summary with
// last set. The receiver cannot stall: results come as one-cycle strobes,
// at most one per cycle. Configuration writes are always ready and belong
// in idle time.
// ----------------------------------------------------------------------------
module mesh_fit_quantize #(
    parameter int MAX_VERTICES = mfq_pkg::MAX_VERTICES_DEF,
    parameter int MAX_FACES    = mfq_pkg::MAX_FACES_DEF,
    parameter int COORD_BITS   = mfq_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic signed [31:0]            i_pos_x,
    input  logic signed [31:0]            i_pos_y,
    input  logic signed [31:0]            i_pos_z,
    input  logic [15:0]                   i_corner_a,
    input  logic [15:0]                   i_corner_b,
    input  logic [15:0]                   i_corner_c,
    // results
    output logic                          o_strobe,
    output logic [1:0]                    o_kind,
    output logic [mfq_pkg::GRID_W-1:0]    o_value_a,
    output logic [mfq_pkg::GRID_W-1:0]    o_value_b,
    output logic [mfq_pkg::GRID_W-1:0]    o_value_c,
    output logic [mfq_pkg::CNT_W-1:0]     o_verts_dropped,
    output logic [mfq_pkg::CNT_W-1:0]     o_faces_dropped,
    output logic [mfq_pkg::CNT_W-1:0]     o_clamp_count,
    output logic [mfq_pkg::FSLOT_W-1:0]   o_filler_count,
    output logic                          o_last,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [mfq_pkg::CFG_W-1:0]     i_cfg_data
);
    import mfq_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int AW = $clog2(MAX_VERTICES);

    // configuration registers
    logic [LG_W-1:0]    r_grid_log2;
    logic [VSLOT_W-1:0] r_vslots;
    logic [FSLOT_W-1:0] r_fslots;
    logic [LG_W-1:0]    w_lg;
    logic [VSLOT_W-1:0] w_vs;
    logic [FSLOT_W-1:0] w_fs;

    // run state
    t_state             r_state, n_state;
    logic [SEEN_W-1:0]  r_vseen, r_fseen;
    logic [CNT_W-1:0]   r_clamps;
    logic [FSLOT_W-1:0] r_ftaken, r_fcnt;
    logic [VSLOT_W-1:0] r_slot;
    logic [CW-1:0]      r_w;

    // output registers
    logic               r_strobe, r_last;
    t_kind              r_kind;
    logic [GRID_W-1:0]  r_a, r_b, r_c;
    logic [CNT_W-1:0]   r_vd, r_fd, r_cc;
    logic [FSLOT_W-1:0] r_fill;

    logic               w_accept, w_vtx, w_face, w_fin, w_face_take;
    logic               w_emit_vtx, w_emit_fill, w_emit_sum, w_width;
    t_lane_ctl          w_ctl;
    logic signed [CW-1:0] w_cx, w_cy, w_cz;
    logic [47:0]        w_ex, w_ey, w_ez;
    logic [3*CW-1:0]    w_rdata;
    logic [CW-1:0]      w_ext [3];
    logic [2:0]         w_lane_busy;
    logic [GRID_W-1:0]  w_digit [3];
    logic [CW-1:0]      w_wmax;
    logic [2:0]         w_clamp;
    logic [15:0]        w_ia, w_ib, w_ic, w_vlast;
    logic [CNT_W:0]     w_csum;
    logic [FSLOT_W-1:0] w_fillers;
    logic [SEEN_W-1:0]  w_vd, w_fd;
    logic               w_slot_full;

    // register clamps
    assign w_lg = (r_grid_log2 < LG_W'(1)) ? LG_W'(1) :
                  (r_grid_log2 > LG_W'(GRID_W)) ? LG_W'(GRID_W) : r_grid_log2;
    assign w_vs = (r_vslots < VSLOT_W'(3)) ? VSLOT_W'(3) :
                  (r_vslots > VSLOT_W'(MAX_VERTICES)) ? VSLOT_W'(MAX_VERTICES) : r_vslots;
    assign w_fs = (r_fslots < FSLOT_W'(1)) ? FSLOT_W'(1) :
                  (r_fslots > FSLOT_W'(MAX_FACES)) ? FSLOT_W'(MAX_FACES) : r_fslots;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_log2 <= LG_W'(4);
            r_vslots    <= VSLOT_W'(8);
            r_fslots    <= FSLOT_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_LOG2:    r_grid_log2 <= i_cfg_data[LG_W-1:0];
                CFG_VERTEX_SLOTS: r_vslots    <= i_cfg_data[VSLOT_W-1:0];
                CFG_FACE_SLOTS:   r_fslots    <= i_cfg_data[FSLOT_W-1:0];
                default: ;
            endcase
        end
    end

    // request decode
    assign w_accept = start && !busy;
    assign w_vtx    = w_accept && (i_opcode == OP_VERTEX);
    assign w_face   = w_accept && (i_opcode == OP_FACE);
    assign w_fin    = w_accept && (i_opcode == OP_FINISH);
    assign w_face_take = w_face && (r_ftaken < w_fs);

    // low COORD_BITS of each coordinate, two's complement
    assign w_ex = 48'(unsigned'(i_pos_x));
    assign w_ey = 48'(unsigned'(i_pos_y));
    assign w_ez = 48'(unsigned'(i_pos_z));
    assign w_cx = $signed(w_ex[CW-1:0]);
    assign w_cy = $signed(w_ey[CW-1:0]);
    assign w_cz = $signed(w_ez[CW-1:0]);

    // face index clamp
    assign w_vlast = 16'(w_vs) - 16'd1;
    assign w_clamp = {i_corner_c >= 16'(w_vs), i_corner_b >= 16'(w_vs),
                      i_corner_a >= 16'(w_vs)};
    assign w_ia = w_clamp[0] ? w_vlast : i_corner_a;
    assign w_ib = w_clamp[1] ? w_vlast : i_corner_b;
    assign w_ic = w_clamp[2] ? w_vlast : i_corner_c;
    assign w_csum = (CNT_W+1)'(r_clamps) + (CNT_W+1)'(w_clamp[0])
                  + (CNT_W+1)'(w_clamp[1]) + (CNT_W+1)'(w_clamp[2]);

    // vertex store
    mfq_ram #(
        .WIDTH (3*CW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_vtx && (r_vseen < SEEN_W'(MAX_VERTICES))),
        .i_waddr (r_vseen[AW-1:0]),
        .i_wdata ({w_cz, w_cy, w_cx}),
        .i_raddr (r_slot[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // three axis lanes
    assign w_slot_full = (SEEN_W'(r_slot) < r_vseen) && (r_w != '0);

    mfq_lane #(.CW(CW)) u_lane_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_ctl), .i_coord (w_cx),
        .i_p ($signed(w_rdata[CW-1:0])), .i_w (r_w), .i_lg (w_lg),
        .o_ext (w_ext[0]), .o_busy (w_lane_busy[0]), .o_digit (w_digit[0])
    );
    mfq_lane #(.CW(CW)) u_lane_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_ctl), .i_coord (w_cy),
        .i_p ($signed(w_rdata[2*CW-1:CW])), .i_w (r_w), .i_lg (w_lg),
        .o_ext (w_ext[1]), .o_busy (w_lane_busy[1]), .o_digit (w_digit[1])
    );
    mfq_lane #(.CW(CW)) u_lane_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_ctl), .i_coord (w_cz),
        .i_p ($signed(w_rdata[3*CW-1:2*CW])), .i_w (r_w), .i_lg (w_lg),
        .o_ext (w_ext[2]), .o_busy (w_lane_busy[2]), .o_digit (w_digit[2])
    );

    // merge: largest extent over the axes
    always_comb begin
        w_wmax = w_ext[0];
        if (w_ext[1] > w_wmax) begin
            w_wmax = w_ext[1];
        end
        if (w_ext[2] > w_wmax) begin
            w_wmax = w_ext[2];
        end
    end

    // summary figures
    assign w_fillers = (w_fs > r_ftaken) ? (w_fs - r_ftaken) : '0;
    assign w_vd = (r_vseen > SEEN_W'(w_vs)) ? (r_vseen - SEEN_W'(w_vs)) : '0;
    assign w_fd = r_fseen - SEEN_W'(r_ftaken);

    // finish sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_fin) begin
                         n_state = S_WIDTH;
                     end
            S_WIDTH: n_state = S_ADDR;
            S_ADDR:  n_state = S_LOAD;
            S_LOAD:  n_state = S_DIV;
            S_DIV:   if (w_lane_busy == 3'b000) begin
                         n_state = (r_slot == w_vs - VSLOT_W'(1)) ? S_FILL : S_ADDR;
                     end
            S_FILL:  if (r_fcnt >= w_fillers) begin
                         n_state = S_SUM;
                     end
            S_SUM:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // finish sequencer: outputs
    always_comb begin
        w_width       = 1'b0;
        w_ctl.upd     = w_vtx;
        w_ctl.start   = 1'b0;
        w_ctl.fill    = w_slot_full;
        w_ctl.clear   = 1'b0;
        w_emit_vtx    = 1'b0;
        w_emit_fill   = 1'b0;
        w_emit_sum    = 1'b0;
        case (r_state)
            S_WIDTH: w_width     = 1'b1;
            S_LOAD:  w_ctl.start = 1'b1;
            S_DIV:   w_emit_vtx  = (w_lane_busy == 3'b000);
            S_FILL:  w_emit_fill = (r_fcnt < w_fillers);
            S_SUM: begin
                w_emit_sum  = 1'b1;
                w_ctl.clear = 1'b1;
            end
            default: ;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vseen  <= '0;
            r_fseen  <= '0;
            r_clamps <= '0;
            r_ftaken <= '0;
            r_slot   <= '0;
            r_fcnt   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_face_take || w_emit_vtx || w_emit_fill || w_emit_sum;
            if (w_vtx && r_vseen != SEEN_MAX) begin
                r_vseen <= r_vseen + SEEN_W'(1);
            end
            if (w_face && r_fseen != SEEN_MAX) begin
                r_fseen <= r_fseen + SEEN_W'(1);
            end
            if (w_face_take) begin
                r_ftaken <= r_ftaken + FSLOT_W'(1);
                r_clamps <= w_csum[CNT_W] ? CNT_MAX : w_csum[CNT_W-1:0];
            end
            if (w_width) begin
                r_slot <= '0;
                r_fcnt <= '0;
            end
            if (w_emit_vtx) begin
                r_slot <= r_slot + VSLOT_W'(1);
            end
            if (w_emit_fill) begin
                r_fcnt <= r_fcnt + FSLOT_W'(1);
            end
            if (w_emit_sum) begin
                r_vseen  <= '0;
                r_fseen  <= '0;
                r_clamps <= '0;
                r_ftaken <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_width) begin
            r_w <= (r_vseen == '0) ? '0 : w_wmax;
        end
        r_last <= w_emit_sum;
        r_vd   <= '0;
        r_fd   <= '0;
        r_cc   <= '0;
        r_fill <= '0;
        if (w_face_take) begin
            r_kind <= KIND_FACE;
            r_a    <= w_ia[GRID_W-1:0];
            r_b    <= w_ib[GRID_W-1:0];
            r_c    <= w_ic[GRID_W-1:0];
        end else if (w_emit_vtx) begin
            r_kind <= KIND_VTX;
            r_a    <= w_digit[0];
            r_b    <= w_digit[1];
            r_c    <= w_digit[2];
        end else if (w_emit_fill) begin
            r_kind <= KIND_FACE;
            r_a    <= GRID_W'(0);
            r_b    <= GRID_W'(1);
            r_c    <= GRID_W'(2);
        end else if (w_emit_sum) begin
            r_kind <= KIND_SUM;
            r_a    <= '0;
            r_b    <= '0;
            r_c    <= '0;
            r_vd   <= (w_vd > SEEN_W'(CNT_MAX)) ? CNT_MAX : w_vd[CNT_W-1:0];
            r_fd   <= (w_fd > SEEN_W'(CNT_MAX)) ? CNT_MAX : w_fd[CNT_W-1:0];
            r_cc   <= r_clamps;
            r_fill <= w_fillers;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_kind          = r_kind;
    assign o_value_a       = r_a;
    assign o_value_b       = r_b;
    assign o_value_c       = r_c;
    assign o_verts_dropped = r_vd;
    assign o_faces_dropped = r_fd;
    assign o_clamp_count   = r_cc;
    assign o_filler_count  = r_fill;
    assign o_last          = r_last;

    // a finish run always ends on its summary
    a_run_ends_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_last))
        else $error("busy dropped without summary");

    // vertex digits only come out of a finish run
    a_vtx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == KIND_VTX) |-> $past(busy))
        else $error("vertex result outside finish run");

    a_ftaken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ftaken <= FSLOT_W'(MAX_FACES))
        else $error("face slot count overflow");
endmodule

// File: verif/tb_mesh_fit_quantize.sv
// ----------------------------------------------------------------------------
// tb_mesh_fit_quantize
// Self-checking bench for the mesh fit and grid quantizer.
// ----------------------------------------------------------------------------
// A behavioral copy of the fitter keeps its own bounding box, vertex store,
// counters and register copies. It predicts the face results and the whole
// finish playout for every accepted request. A monitor compares each result
// strobe with the oldest prediction. Directed tests cover the corner cases.
// Random mesh runs under changing register settings follow them.
// ----------------------------------------------------------------------------
module tb_mesh_fit_quantize;
    import mfq_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;   // opcode the block ignores
    localparam int SLOT_CAP   = 32;
    localparam int FACE_CAP   = 31;
    localparam int SETTLE_CYC = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] val_a;
        logic [11:0] val_b;
        logic [11:0] val_c;
        logic [15:0] vdrop;
        logic [15:0] fdrop;
        logic [15:0] clamps;
        logic [4:0]  fill;
        logic        last;
    } t_fit_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic [15:0]        i_corner_a, i_corner_b, i_corner_c;
    logic               o_strobe;
    logic [1:0]         o_kind;
    logic [11:0]        o_value_a, o_value_b, o_value_c;
    logic [15:0]        o_verts_dropped, o_faces_dropped, o_clamp_count;
    logic [4:0]         o_filler_count;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [5:0]         i_cfg_data;

    mesh_fit_quantize dut (.*);

    // fitter copy: registers and state
    logic [3:0]  grid_lg_reg;
    logic [5:0]  vslots_reg;
    logic [4:0]  fslots_reg;
    longint      box_lo[3], box_hi[3];
    longint      vtx_mem[SLOT_CAP][3];
    int unsigned n_verts, n_faces, n_clamps, n_taken;

    t_fit_result pending_results[$];
    int          mismatches;
    int          items_sent;
    bit          no_gaps;   // sender idling off for a stretch

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // generous fixed limit; slowest run is well under a tenth of this
    initial begin
        #(20 * 2000000);
        $display("FAIL");
        $finish;
    end

    function automatic void clear_fit();
        for (int k = 0; k < 3; k++) begin
            box_lo[k] = 64'sd2147483647;
            box_hi[k] = -64'sd2147483648;
        end
        n_verts  = 0;
        n_faces  = 0;
        n_clamps = 0;
        n_taken  = 0;
    endfunction

    // floor(((2p - s) + w) * C / (2w)), clamped to the grid
    function automatic logic [11:0] grid_digit(longint p, longint s, longint w, int lg);
        longint cells, num, q;
        cells = longint'(1) << lg;
        if (w <= 0) return 12'(cells / 2);
        num = 2 * p - s + w;
        if (num < 0) return 12'd0;
        if (num > 2 * w) num = 2 * w;
        q = (num << lg) / (2 * w);
        if (q > cells - 1) q = cells - 1;
        return 12'(q);
    endfunction

    task automatic predict_request(logic [1:0] op, logic signed [31:0] px,
                                   logic signed [31:0] py, logic signed [31:0] pz,
                                   logic [15:0] ca, logic [15:0] cb, logic [15:0] cc);
        int          lg, vs, fs;
        longint      pos[3], span;
        logic [15:0] idx[3];
        t_fit_result r;
        int unsigned fill, vd, fd;
        lg = (grid_lg_reg < 1) ? 1 : ((grid_lg_reg > 12) ? 12 : int'(grid_lg_reg));
        vs = (vslots_reg < 3) ? 3 : ((vslots_reg > SLOT_CAP) ? SLOT_CAP : int'(vslots_reg));
        fs = (fslots_reg < 1) ? 1 : ((fslots_reg > FACE_CAP) ? FACE_CAP : int'(fslots_reg));
        pos[0] = px; pos[1] = py; pos[2] = pz;
        idx[0] = ca; idx[1] = cb; idx[2] = cc;
        r = '0;
        case (op)
            OP_VERTEX: begin
                for (int k = 0; k < 3; k++) begin
                    if (pos[k] < box_lo[k]) box_lo[k] = pos[k];
                    if (pos[k] > box_hi[k]) box_hi[k] = pos[k];
                    if (n_verts < SLOT_CAP) vtx_mem[n_verts][k] = pos[k];
                end
                if (n_verts < 131071) n_verts++;
            end
            OP_FACE: begin
                if (n_faces < 131071) n_faces++;
                if (n_taken < fs) begin
                    for (int k = 0; k < 3; k++) begin
                        if (idx[k] >= vs) begin
                            idx[k] = 16'(vs - 1);
                            if (n_clamps < 65535) n_clamps++;
                        end
                    end
                    n_taken++;
                    r.kind  = KIND_FACE;
                    r.val_a = idx[0][11:0];
                    r.val_b = idx[1][11:0];
                    r.val_c = idx[2][11:0];
                    pending_results.push_back(r);
                end
            end
            OP_FINISH: begin
                span = 0;
                if (n_verts > 0)
                    for (int k = 0; k < 3; k++)
                        if (box_hi[k] - box_lo[k] > span) span = box_hi[k] - box_lo[k];
                for (int i = 0; i < vs; i++) begin
                    r = '0;
                    r.kind = KIND_VTX;
                    if (i < n_verts) begin
                        r.val_a = grid_digit(vtx_mem[i][0], box_lo[0] + box_hi[0], span, lg);
                        r.val_b = grid_digit(vtx_mem[i][1], box_lo[1] + box_hi[1], span, lg);
                        r.val_c = grid_digit(vtx_mem[i][2], box_lo[2] + box_hi[2], span, lg);
                    end else begin
                        r.val_a = 12'((1 << lg) / 2);
                        r.val_b = r.val_a;
                        r.val_c = r.val_a;
                    end
                    pending_results.push_back(r);
                end
                fill = (n_taken < fs) ? fs - n_taken : 0;
                for (int i = 0; i < fill; i++) begin
                    r = '0;
                    r.kind  = KIND_FACE;
                    r.val_b = 12'd1;
                    r.val_c = 12'd2;
                    pending_results.push_back(r);
                end
                vd = (n_verts > vs) ? n_verts - vs : 0;
                if (vd > 65535) vd = 65535;
                fd = (n_faces > n_taken) ? n_faces - n_taken : 0;
                if (fd > 65535) fd = 65535;
                r = '0;
                r.kind   = KIND_SUM;
                r.vdrop  = 16'(vd);
                r.fdrop  = 16'(fd);
                r.clamps = 16'(n_clamps);
                r.fill   = 5'(fill);
                r.last   = 1'b1;
                pending_results.push_back(r);
                clear_fit();
            end
            default: ;  // unused opcode: ignored
        endcase
    endtask

    // result monitor: the block cannot be stalled, every strobe is a result
    always @(posedge i_clk) begin
        t_fit_result got, want;
        if (i_rst_n && o_strobe) begin
            got = '{o_kind, o_value_a, o_value_b, o_value_c, o_verts_dropped,
                    o_faces_dropped, o_clamp_count, o_filler_count, o_last};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d a=%0d b=%0d c=%0d",
                             got.kind, got.val_a, got.val_b, got.val_c);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp kind=%0d abc=%0d/%0d/%0d vd=%0d fd=%0d cc=%0d fill=%0d last=%0d",
                                 want.kind, want.val_a, want.val_b, want.val_c, want.vdrop,
                                 want.fdrop, want.clamps, want.fill, want.last);
                        $display("         got kind=%0d abc=%0d/%0d/%0d vd=%0d fd=%0d cc=%0d fill=%0d last=%0d",
                                 got.kind, got.val_a, got.val_b, got.val_c, got.vdrop,
                                 got.fdrop, got.clamps, got.fill, got.last);
                    end
                end
            end
        end
    end

    // one request; returns in the time step of the accepting edge, start still high
    task automatic send_request(logic [1:0] op, logic signed [31:0] px = 0,
                                logic signed [31:0] py = 0, logic signed [31:0] pz = 0,
                                logic [15:0] ca = 0, logic [15:0] cb = 0,
                                logic [15:0] cc = 0);
        if (!no_gaps && $urandom_range(99) < 20) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_opcode   <= op;
        i_pos_x    <= px;
        i_pos_y    <= py;
        i_pos_z    <= pz;
        i_corner_a <= ca;
        i_corner_b <= cb;
        i_corner_c <= cc;
        do @(posedge i_clk); while (busy);
        predict_request(op, px, py, pz, ca, cb, cc);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // drop start, let every prediction arrive, then let a dropped face settle
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [5:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GRID_LOG2:    grid_lg_reg = value[3:0];
            CFG_VERTEX_SLOTS: vslots_reg  = value;
            default:          fslots_reg  = value[4:0];
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [5:0] lg, logic [5:0] vs, logic [5:0] fs);
        drain_results();
        write_reg(CFG_GRID_LOG2, lg);
        write_reg(CFG_VERTEX_SLOTS, vs);
        write_reg(CFG_FACE_SLOTS, fs);
        @(posedge i_clk);
    endtask

    // empty finish, single vertex (zero extent), extreme coordinates,
    // clamped and passed indices, faces past the slots, unused opcode
    task automatic test_directed();
        send_request(OP_FINISH);
        send_request(OP_VERTEX, 32'sd5, -32'sd7, 32'sd9);
        send_request(OP_FINISH);
        send_request(OP_VERTEX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_VERTEX, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_VERTEX, 32'sd0, 32'sd65536, -32'sd65536);
        send_request(OP_UNUSED, 32'sd1, 32'sd1, 32'sd1, 16'd1, 16'd1, 16'd1);
        send_request(OP_FACE, 0, 0, 0, 16'd0, 16'd1, 16'd2);
        send_request(OP_FACE, 0, 0, 0, 16'hFFFF, 16'd7, 16'd8);
        send_request(OP_FACE, 0, 0, 0, 16'h5555, 16'hAAAA, 16'd3);
        for (int i = 0; i < 7; i++)
            send_request(OP_FACE, 0, 0, 0, 16'(i), 16'(i + 1), 16'(i + 2));
        send_request(OP_FINISH);
    endtask

    // register extremes, including values outside the used ranges
    task automatic test_reg_extremes();
        set_regs(6'd1, 6'd3, 6'd1);
        send_request(OP_VERTEX, 32'sd0, 32'sd0, 32'sd0);
        send_request(OP_VERTEX, 32'sd100, 32'sd50, -32'sd100);
        send_request(OP_FACE, 0, 0, 0, 16'd3, 16'd2, 16'd1);
        send_request(OP_FACE, 0, 0, 0, 16'd0, 16'd0, 16'd0);
        send_request(OP_FINISH);
        set_regs(6'd12, 6'd32, 6'd31);
        for (int i = 0; i < 34; i++)
            send_request(OP_VERTEX, $urandom, $urandom, $urandom);
        send_request(OP_FACE, 0, 0, 0, 16'd31, 16'd32, 16'd40);
        send_request(OP_FINISH);
        set_regs(6'd0, 6'd0, 6'd0);
        send_request(OP_VERTEX, -32'sd3, 32'sd4, 32'sd9);
        send_request(OP_FINISH);
        set_regs(6'd15, 6'd63, 6'd31);
        send_request(OP_VERTEX, 32'sd1, 32'sd2, 32'sd3);
        send_request(OP_VERTEX, 32'sd8, -32'sd2, 32'sd3);
        send_request(OP_FINISH);
    endtask

    // sender holds off until the block has played everything out
    task automatic test_drain_pause();
        set_regs(6'd4, 6'd8, 6'd8);
        send_request(OP_VERTEX, 32'sd10, 32'sd20, 32'sd30);
        send_request(OP_FACE, 0, 0, 0, 16'd0, 16'd9, 16'd1);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        send_request(OP_VERTEX, -32'sd10, 32'sd0, 32'sd1000);
        send_request(OP_FINISH);
    endtask

    // random meshes: mostly vertices then faces then finish, with some
    // shuffled order, noise opcodes and register changes between meshes
    task automatic test_random_meshes();
        int          nv, nf, shape;
        logic signed [31:0] base[3], pt[3];
        logic [15:0] lim;
        int          mesh;
        mesh = 0;
        while (items_sent < 330) begin
            mesh++;
            no_gaps = (mesh >= 6 && mesh < 10);
            if ($urandom_range(99) < 30)
                set_regs(6'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 31)));
            nv    = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 10);
            nf    = ($urandom_range(9) == 0) ? $urandom_range(25, 35) : $urandom_range(0, 8);
            shape = $urandom_range(2);
            for (int k = 0; k < 3; k++) base[k] = $urandom;
            for (int k = 0; k < 3; k++) base[k] = base[k] >>> 2;
            lim = ($urandom_range(1)) ? 16'hFFFF : 16'd40;
            while (nv + nf > 0) begin
                if ($urandom_range(19) == 0)
                    send_request(OP_UNUSED, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                if (nv > 0 && (nf == 0 || $urandom_range(9) != 0)) begin
                    for (int k = 0; k < 3; k++)
                        pt[k] = (shape == 0) ? $urandom :
                                (shape == 1) ? base[k] + $urandom_range(0, 4095) : base[k];
                    send_request(OP_VERTEX, pt[0], pt[1], pt[2]);
                    nv--;
                end else begin
                    send_request(OP_FACE, 0, 0, 0, 16'($urandom_range(0, lim)),
                                 16'($urandom_range(0, lim)), 16'($urandom_range(0, lim)));
                    nf--;
                end
            end
            send_request(OP_FINISH);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        int guard;
        mismatches  = 0;
        items_sent  = 0;
        no_gaps     = 1'b0;
        grid_lg_reg = 4'd4;
        vslots_reg  = 6'd8;
        fslots_reg  = 5'd8;
        clear_fit();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_opcode    <= OP_VERTEX;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pos_z     <= '0;
        i_corner_a  <= '0;
        i_corner_b  <= '0;
        i_corner_c  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_GRID_LOG2;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_reg_extremes();
        test_drain_pause();
        test_random_meshes();

        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
